>>> design/apsp_pkg.sv
`default_nettype none
package apsp_pkg;

	localparam int NV_W     = 5;
	localparam int OP_W     = 2;
	localparam int VTX_W    = 4;
	localparam int WEIGHT_W = 16;
	localparam int HOP_W    = 4;
	localparam logic [NV_W-1:0] NV_RESET = 5'd16;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_RUN   = 2'd1,
		OP_QUERY = 2'd2
	} opcode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WRITE,
		S_CP_RD,
		S_CP_WR,
		S_ROW_RD,
		S_ROW_LD,
		S_REL_RD,
		S_REL_WR,
		S_Q_RD,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		RD_COPY,
		RD_ROW,
		RD_REL,
		RD_QUERY
	} rd_sel_t;

	typedef enum logic [2:0] {
		CNT_HOLD,
		CNT_CLR,
		CNT_J,
		CNT_JI,
		CNT_JIK
	} cnt_op_t;

	typedef struct packed {
		logic    cap;
		logic    edge_we;
		rd_sel_t rd_sel;
		logic    copy_we;
		logic    hold_ik;
		logic    relax;
		cnt_op_t cnt_op;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic n_zero;
		logic last_i;
		logic last_j;
		logic last_k;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

>>> design/all_pairs_shortest_path_top.sv
// Floyd-Warshall all-pairs shortest path engine for up to MAX_VERTICES vertices. Opcode 0
// writes one edge weight (65535 = no edge), opcode 1 runs the all-pairs computation over the
// first num_vertices vertices, opcode 2 reads back one distance and next hop; every item
// returns exactly one result beat; for a write or query, status is 1 when row or column is
// out of range. Load every edge among the active vertices before a run, and run before
// querying. A write or a query holds off new input until its result is loaded into the
// output register. A run first copies every edge weight into the distance store, which has
// a single write port, then for each (k, i) row fetches d[i][k] and relaxes each entry.
// The output register lets the next item be accepted while a result waits.
`default_nettype none
module all_pairs_shortest_path_top #(
	parameter int MAX_VERTICES = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [apsp_pkg::NV_W-1:0]     cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [apsp_pkg::OP_W-1:0]     opcode,
	input  wire logic [apsp_pkg::VTX_W-1:0]    row,
	input  wire logic [apsp_pkg::VTX_W-1:0]    col,
	input  wire logic [apsp_pkg::WEIGHT_W-1:0] weight,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               status,
	output logic [apsp_pkg::WEIGHT_W-1:0]      distance,
	output logic [apsp_pkg::HOP_W-1:0]         next_hop
);

	apsp_pkg::cmd_t  cmd;
	apsp_pkg::stat_t stat;

	apsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	apsp_dp #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.opcode    (opcode),
		.row       (row),
		.col       (col),
		.weight    (weight),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.distance  (distance),
		.next_hop  (next_hop)
	);

endmodule
`default_nettype wire

>>> design/apsp_ctrl.sv
`default_nettype none
module apsp_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [1:0]       opcode,
	output logic                  in_stall,
	input  wire apsp_pkg::stat_t  stat,
	output apsp_pkg::cmd_t        cmd
);

	apsp_pkg::state_t state_q, state_nxt;
	logic accept;

	assign in_stall = (state_q != apsp_pkg::S_IDLE);
	assign accept   = in_valid && (state_q == apsp_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= apsp_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			apsp_pkg::S_IDLE: begin
				if (accept) begin
					case (opcode)
						apsp_pkg::OP_WRITE: state_nxt = apsp_pkg::S_WRITE;
						apsp_pkg::OP_RUN:   state_nxt = apsp_pkg::S_CP_RD;
						apsp_pkg::OP_QUERY: state_nxt = apsp_pkg::S_Q_RD;
						default:            state_nxt = apsp_pkg::S_DONE;
					endcase
				end
			end
			apsp_pkg::S_WRITE: state_nxt = apsp_pkg::S_DONE;
			apsp_pkg::S_Q_RD:  state_nxt = apsp_pkg::S_DONE;
			apsp_pkg::S_CP_RD: begin
				if (stat.n_zero) begin
					state_nxt = apsp_pkg::S_DONE;
				end else begin
					state_nxt = apsp_pkg::S_CP_WR;
				end
			end
			apsp_pkg::S_CP_WR: begin
				if (stat.last_j && stat.last_i) begin
					state_nxt = apsp_pkg::S_ROW_RD;
				end else begin
					state_nxt = apsp_pkg::S_CP_RD;
				end
			end
			apsp_pkg::S_ROW_RD: state_nxt = apsp_pkg::S_ROW_LD;
			apsp_pkg::S_ROW_LD: state_nxt = apsp_pkg::S_REL_RD;
			apsp_pkg::S_REL_RD: state_nxt = apsp_pkg::S_REL_WR;
			apsp_pkg::S_REL_WR: begin
				if (!stat.last_j) begin
					state_nxt = apsp_pkg::S_REL_RD;
				end else if (stat.last_i && stat.last_k) begin
					state_nxt = apsp_pkg::S_DONE;
				end else begin
					state_nxt = apsp_pkg::S_ROW_RD;
				end
			end
			apsp_pkg::S_DONE: begin
				if (stat.out_free) begin
					state_nxt = apsp_pkg::S_IDLE;
				end
			end
			default: state_nxt = apsp_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.rd_sel   = apsp_pkg::RD_QUERY;
		cmd.cnt_op   = apsp_pkg::CNT_HOLD;
		case (state_q)
			apsp_pkg::S_IDLE: begin
				if (accept) begin
					cmd.cap    = 1'b1;
					cmd.cnt_op = apsp_pkg::CNT_CLR;
				end
			end
			apsp_pkg::S_WRITE: cmd.edge_we = 1'b1;
			apsp_pkg::S_Q_RD:  cmd.rd_sel  = apsp_pkg::RD_QUERY;
			apsp_pkg::S_CP_RD: cmd.rd_sel  = apsp_pkg::RD_COPY;
			apsp_pkg::S_CP_WR: begin
				cmd.rd_sel  = apsp_pkg::RD_COPY;
				cmd.copy_we = 1'b1;
				if (stat.last_j && stat.last_i) begin
					cmd.cnt_op = apsp_pkg::CNT_CLR;
				end else if (stat.last_j) begin
					cmd.cnt_op = apsp_pkg::CNT_JI;
				end else begin
					cmd.cnt_op = apsp_pkg::CNT_J;
				end
			end
			apsp_pkg::S_ROW_RD: cmd.rd_sel = apsp_pkg::RD_ROW;
			apsp_pkg::S_ROW_LD: begin
				cmd.rd_sel  = apsp_pkg::RD_ROW;
				cmd.hold_ik = 1'b1;
			end
			apsp_pkg::S_REL_RD: cmd.rd_sel = apsp_pkg::RD_REL;
			apsp_pkg::S_REL_WR: begin
				cmd.rd_sel = apsp_pkg::RD_REL;
				cmd.relax  = 1'b1;
				if (!stat.last_j) begin
					cmd.cnt_op = apsp_pkg::CNT_J;
				end else if (!stat.last_i) begin
					cmd.cnt_op = apsp_pkg::CNT_JI;
				end else if (!stat.last_k) begin
					cmd.cnt_op = apsp_pkg::CNT_JIK;
				end
			end
			apsp_pkg::S_DONE: cmd.out_load = stat.out_free;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

>>> design/apsp_dp.sv
`default_nettype none
module apsp_dp #(
	parameter int MAX_VERTICES = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [apsp_pkg::NV_W-1:0]         cfg_wdata,
	input  wire logic [apsp_pkg::OP_W-1:0]         opcode,
	input  wire logic [apsp_pkg::VTX_W-1:0]        row,
	input  wire logic [apsp_pkg::VTX_W-1:0]        col,
	input  wire logic [apsp_pkg::WEIGHT_W-1:0]     weight,
	input  wire apsp_pkg::cmd_t                    cmd,
	output apsp_pkg::stat_t                        stat,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   status,
	output logic [apsp_pkg::WEIGHT_W-1:0]          distance,
	output logic [apsp_pkg::HOP_W-1:0]             next_hop
);

	localparam int IDX_W  = $clog2(MAX_VERTICES);
	localparam int CW     = (IDX_W > apsp_pkg::NV_W) ? IDX_W : apsp_pkg::NV_W;
	localparam int ADDR_W = 2 * IDX_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int WW     = apsp_pkg::WEIGHT_W;

	logic [apsp_pkg::NV_W-1:0]  nv_q;
	logic [apsp_pkg::NV_W-1:0]  n_act;
	logic [apsp_pkg::NV_W-1:0]  n_m1;
	logic [apsp_pkg::OP_W-1:0]  op_q;
	logic [apsp_pkg::VTX_W-1:0] row_q;
	logic [apsp_pkg::VTX_W-1:0] col_q;
	logic [WW-1:0]              weight_q;
	logic                       in_range;

	logic [CW-1:0]    i_q, j_q, k_q;
	logic [IDX_W-1:0] ii, jj, kk;
	logic [ADDR_W-1:0] addr_ij, addr_ik, addr_kj, addr_rc;
	logic [ADDR_W-1:0] addr_a, addr_b, addr_n;

	logic [WW-1:0]    edge_mem [DEPTH];
	logic [WW-1:0]    dist_mem [DEPTH];
	logic [IDX_W-1:0] hop_mem  [DEPTH];

	logic [WW-1:0]    edge_rd_q;
	logic [WW-1:0]    rd_a_q;
	logic [WW-1:0]    rd_b_q;
	logic [IDX_W-1:0] rd_n_q;
	logic [WW-1:0]    dik_q;
	logic [IDX_W-1:0] nik_q;

	logic [WW:0]      via;
	logic             less;
	logic             dist_we;
	logic [WW-1:0]    dist_wdata;
	logic [IDX_W-1:0] hop_wdata;

	logic             out_valid_q;
	logic             status_q;
	logic [WW-1:0]    distance_q;
	logic [apsp_pkg::HOP_W-1:0] next_hop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nv_q <= apsp_pkg::NV_RESET;
		end else if (cfg_we) begin
			nv_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (int'(nv_q) > MAX_VERTICES) begin
			n_act = apsp_pkg::NV_W'(MAX_VERTICES);
		end else begin
			n_act = nv_q;
		end
	end

	assign n_m1     = n_act - apsp_pkg::NV_W'(1);
	assign in_range = (CW'(row_q) < CW'(n_act)) && (CW'(col_q) < CW'(n_act));

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q     <= opcode;
			row_q    <= row;
			col_q    <= col;
			weight_q <= weight;
		end
	end

	// loop counters: j innermost, then i, then k
	always_ff @(posedge clk) begin
		case (cmd.cnt_op)
			apsp_pkg::CNT_CLR: begin
				i_q <= '0;
				j_q <= '0;
				k_q <= '0;
			end
			apsp_pkg::CNT_J: j_q <= j_q + CW'(1);
			apsp_pkg::CNT_JI: begin
				j_q <= '0;
				i_q <= i_q + CW'(1);
			end
			apsp_pkg::CNT_JIK: begin
				j_q <= '0;
				i_q <= '0;
				k_q <= k_q + CW'(1);
			end
			default: ;
		endcase
	end

	assign stat.n_zero   = (n_act == '0);
	assign stat.last_i   = (i_q == CW'(n_m1));
	assign stat.last_j   = (j_q == CW'(n_m1));
	assign stat.last_k   = (k_q == CW'(n_m1));
	assign stat.out_free = !out_valid_q || !out_stall;

	assign ii      = IDX_W'(i_q);
	assign jj      = IDX_W'(j_q);
	assign kk      = IDX_W'(k_q);
	assign addr_ij = {ii, jj};
	assign addr_ik = {ii, kk};
	assign addr_kj = {kk, jj};
	assign addr_rc = {IDX_W'(row_q), IDX_W'(col_q)};

	always_comb begin
		addr_a = addr_ij;
		addr_b = addr_ij;
		addr_n = addr_ij;
		case (cmd.rd_sel)
			apsp_pkg::RD_ROW: begin
				addr_a = addr_ik;
				addr_n = addr_ik;
			end
			apsp_pkg::RD_REL: begin
				addr_a = addr_kj;
				addr_b = addr_ij;
			end
			apsp_pkg::RD_QUERY: begin
				addr_b = addr_rc;
				addr_n = addr_rc;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.edge_we && in_range) begin
			edge_mem[addr_rc] <= weight_q;
		end
		edge_rd_q <= edge_mem[addr_ij];
	end

	assign via  = {1'b0, dik_q} + {1'b0, rd_a_q};
	assign less = (via < {1'b0, rd_b_q});

	assign dist_we    = cmd.copy_we || (cmd.relax && less);
	assign dist_wdata = cmd.copy_we ? edge_rd_q : via[WW-1:0];
	assign hop_wdata  = cmd.copy_we ? jj : nik_q;

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[addr_ij] <= dist_wdata;
		end
		rd_a_q <= dist_mem[addr_a];
		rd_b_q <= dist_mem[addr_b];
	end

	always_ff @(posedge clk) begin
		if (dist_we) begin
			hop_mem[addr_ij] <= hop_wdata;
		end
		rd_n_q <= hop_mem[addr_n];
	end

	always_ff @(posedge clk) begin
		if (cmd.hold_ik) begin
			dik_q <= rd_a_q;
			nik_q <= rd_n_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status_q   <= 1'b0;
			distance_q <= '0;
			next_hop_q <= '0;
			if (op_q == apsp_pkg::OP_WRITE) begin
				status_q <= !in_range;
			end else if (op_q == apsp_pkg::OP_QUERY) begin
				status_q <= !in_range;
				if (in_range) begin
					distance_q <= rd_b_q;
					next_hop_q <= apsp_pkg::HOP_W'(rd_n_q);
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign distance  = distance_q;
	assign next_hop  = next_hop_q;

endmodule
`default_nettype wire
